// ----- hw/rtl/csv_field_extractor_assert.svh -----
// ----------------------------------------------------------------------------
// csv_field_extractor assertion macros
// clocked on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef CSV_FIELD_EXTRACTOR_ASSERT_SVH
`define CSV_FIELD_EXTRACTOR_ASSERT_SVH

// same-cycle implication
`define CFE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CFE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/cfe_pkg.sv -----
// ----------------------------------------------------------------------------
// cfe_pkg
// shared types and constants of the csv field extractor
// ----------------------------------------------------------------------------
package cfe_pkg;

  localparam int BYTE_W = 8;
  localparam int CNT_W  = 12;

  localparam logic [BYTE_W-1:0] QUOTE_CH = 8'h22;
  localparam logic [BYTE_W-1:0] LF_CH    = 8'h0A;
  localparam logic [BYTE_W-1:0] CR_CH    = 8'h0D;
  localparam logic [BYTE_W-1:0] EOL_CH   = 8'h00;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_DELIMITER   = 2'd0;
  localparam logic [1:0] REG_FIELD_INDEX = 2'd1;
  localparam logic [1:0] REG_MAX_CHARS   = 2'd2;

  localparam logic [BYTE_W-1:0] DELIMITER_RST   = 8'd44;
  localparam logic [CNT_W-1:0]  FIELD_INDEX_RST = 12'd0;
  localparam logic [CNT_W-1:0]  MAX_CHARS_RST   = 12'd255;

  typedef enum logic [5:0] {
    PH_SKIP   = 6'b000001,
    PH_START  = 6'b000010,
    PH_UNQ    = 6'b000100,
    PH_QUOTED = 6'b001000,
    PH_PEND   = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [BYTE_W-1:0] delimiter;
    logic [CNT_W-1:0]  field_index;
    logic [CNT_W-1:0]  max_chars;
  } cfe_cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] field_byte;
    logic              byte_valid;
    logic              field_done;
    logic              field_found;
  } cfe_result_t;

endpackage

// ----- hw/rtl/cfe_regs.sv -----
// ----------------------------------------------------------------------------
// cfe_regs
// apb configuration registers
// ----------------------------------------------------------------------------
module cfe_regs
  import cfe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output cfe_cfg_t    cfg_o
);

  cfe_cfg_t cfg_q, cfg_d;
  logic     wr_en;

  assign wr_en = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[3:2])
        REG_DELIMITER:   cfg_d.delimiter   = pwdata[BYTE_W-1:0];
        REG_FIELD_INDEX: cfg_d.field_index = pwdata[CNT_W-1:0];
        REG_MAX_CHARS:   cfg_d.max_chars   = pwdata[CNT_W-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delimiter   <= DELIMITER_RST;
      cfg_q.field_index <= FIELD_INDEX_RST;
      cfg_q.max_chars   <= MAX_CHARS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_DELIMITER:   prdata = {24'd0, cfg_q.delimiter};
      REG_FIELD_INDEX: prdata = {20'd0, cfg_q.field_index};
      REG_MAX_CHARS:   prdata = {20'd0, cfg_q.max_chars};
      default:         prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/cfe_parser.sv -----
// ----------------------------------------------------------------------------
// cfe_parser
// line state and one-byte step of the field extractor
// ----------------------------------------------------------------------------
module cfe_parser
  import cfe_pkg::*;
#(
  parameter int LINE_LEN_MAX = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [BYTE_W-1:0] byte_i,
  input  cfe_cfg_t          cfg_i,
  output logic              emit_o,
  output cfe_result_t       res_o
);

  localparam logic [CNT_W-1:0] CAP =
    (LINE_LEN_MAX - 1 > (1 << CNT_W) - 1) ? {CNT_W{1'b1}} : CNT_W'(LINE_LEN_MAX - 1);

  phase_e           phase_q, phase_d;
  logic [CNT_W-1:0] fcount_q, fcount_d;
  logic             inq_q, inq_d;
  logic [CNT_W-1:0] ocount_q, ocount_d;

  logic [CNT_W-1:0] limit;
  logic             full, is_eol, is_quote, is_end;
  logic             do_done, do_char, found;
  logic [BYTE_W-1:0] char_val;

  assign limit    = (cfg_i.max_chars < CAP) ? cfg_i.max_chars : CAP;
  assign full     = ocount_q >= limit;
  assign is_eol   = byte_i == EOL_CH;
  assign is_quote = byte_i == QUOTE_CH;
  assign is_end   = (byte_i == cfg_i.delimiter) || (byte_i == CR_CH) || (byte_i == LF_CH);

  always_comb begin
    phase_d  = phase_q;
    fcount_d = fcount_q;
    inq_d    = inq_q;
    ocount_d = ocount_q;
    do_done  = 1'b0;
    do_char  = 1'b0;
    found    = 1'b1;
    char_val = byte_i;

    if (phase_q == PH_SKIP && fcount_q < cfg_i.field_index) begin
      if (is_eol) begin
        do_done = 1'b1;
        found   = 1'b0;
      end else begin
        if (is_quote) begin
          inq_d = ~inq_q;
        end else if (!inq_q && byte_i == cfg_i.delimiter) begin
          fcount_d = fcount_q + 1'b1;
        end
        if (fcount_d >= cfg_i.field_index) begin
          phase_d = PH_START;
        end
      end
    end else begin
      case (phase_q)
        PH_SKIP, PH_START: begin
          // an opening quote wins over a delimiter of the same value
          if (is_eol) begin
            do_done = 1'b1;
            found   = 1'b0;
          end else if (full) begin
            do_done = 1'b1;
          end else if (is_quote) begin
            phase_d = PH_QUOTED;
          end else if (is_end) begin
            do_done = 1'b1;
          end else begin
            phase_d = PH_UNQ;
            do_char = 1'b1;
          end
        end
        PH_UNQ: begin
          if (is_eol || full || is_end) do_done = 1'b1;
          else                          do_char = 1'b1;
        end
        PH_QUOTED: begin
          if (is_eol || full) begin
            do_done = 1'b1;
          end else if (is_quote) begin
            phase_d = PH_PEND;
          end else begin
            do_char = 1'b1;
          end
        end
        PH_PEND: begin
          if (is_quote) begin
            phase_d  = PH_QUOTED;
            do_char  = 1'b1;
            char_val = QUOTE_CH;
          end else begin
            do_done = 1'b1;
          end
        end
        default: begin
          // waiting for the end of the line
          if (is_eol) phase_d = PH_SKIP;
        end
      endcase
    end

    if (do_char) begin
      ocount_d = ocount_q + 1'b1;
    end
    if (do_done) begin
      phase_d = PH_DONE;
    end
    // end of line clears the line state
    if (is_eol && (do_done || phase_q == PH_DONE)) begin
      phase_d  = PH_SKIP;
      fcount_d = '0;
      inq_d    = 1'b0;
      ocount_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SKIP;
      fcount_q <= '0;
      inq_q    <= 1'b0;
      ocount_q <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      fcount_q <= fcount_d;
      inq_q    <= inq_d;
      ocount_q <= ocount_d;
    end
  end

  assign emit_o            = step_i && (do_char || do_done);
  assign res_o.field_byte  = do_char ? char_val : '0;
  assign res_o.byte_valid  = do_char;
  assign res_o.field_done  = do_done;
  assign res_o.field_found = do_done && found;

endmodule

// ----- hw/rtl/cfe_out_buf.sv -----
// ----------------------------------------------------------------------------
// cfe_out_buf
// two-entry result queue between the parser and the output channel
// ----------------------------------------------------------------------------
module cfe_out_buf
  import cfe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  cfe_result_t data_i,
  output logic        full_o,
  output logic        valid_o,
  input  logic        ready_i,
  output cfe_result_t data_o
);

  cfe_result_t ent_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q, cnt_d;
  logic        pop;

  assign valid_o = cnt_q != 2'd0;
  assign full_o  = cnt_q == 2'd2;
  assign pop     = valid_o && ready_i;
  assign data_o  = ent_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop)      cnt_d = cnt_q + 2'd1;
    else if (!push_i && pop) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop)    rd_ptr_q <= ~rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wr_ptr_q] <= data_i;
  end

endmodule

// ----- hw/rtl/csv_field_extractor.sv -----
// ----------------------------------------------------------------------------
// csv_field_extractor
// pulls one selected field out of a csv line streamed a byte at a time
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake               payload
//  --------  ---------  ----------------------  ---------------------------------
//  in        input      in_valid_i/in_ready_o   line_byte_i
//  out       output     out_valid_o/out_ready_i field_byte_o, byte_valid_o,
//                                               field_done_o, field_found_o
//  config    input      apb psel/penable/pready paddr, pwdata, prdata
//
//  one byte per cycle sustained while the result queue has room,
//  set by the single parser step per cycle; path: input reg, then result queue
//  reset: asynchronous, clears line state, config back to its defaults
//  output stalls are absorbed by a two-entry result queue; input stalls
//  only when that queue is full
//
module csv_field_extractor
  import cfe_pkg::*;
#(
  parameter int LINE_LEN_MAX = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // byte stream
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [BYTE_W-1:0] line_byte_i,
  // result stream
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BYTE_W-1:0] field_byte_o,
  output logic              byte_valid_o,
  output logic              field_done_o,
  output logic              field_found_o,
  // apb config port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfe_cfg_t          cfg;
  cfe_result_t       res, out_res;
  logic              emit, obuf_full;
  logic              in_vld_q, in_vld_d;
  logic [BYTE_W-1:0] in_byte_q;
  logic              in_fire, step;

  assign pready = 1'b1;

  cfe_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  // input register; the parser consumes it whenever the queue has room
  assign step       = in_vld_q && !obuf_full;
  assign in_ready_o = !in_vld_q || step;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_fire)   in_vld_d = 1'b1;
    else if (step) in_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_fire) in_byte_q <= line_byte_i;
  end

  cfe_parser #(
    .LINE_LEN_MAX (LINE_LEN_MAX)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .cfg_i  (cfg),
    .emit_o (emit),
    .res_o  (res)
  );

  cfe_out_buf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (emit),
    .data_i  (res),
    .full_o  (obuf_full),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_res)
  );

  assign field_byte_o  = out_res.field_byte;
  assign byte_valid_o  = out_res.byte_valid;
  assign field_done_o  = out_res.field_done;
  assign field_found_o = out_res.field_found;

endmodule

// ----- hw/rtl/cfe_checker.sv -----
// ----------------------------------------------------------------------------
// cfe_checker
// port-level checks of the csv field extractor
// ----------------------------------------------------------------------------
`include "csv_field_extractor_assert.svh"

module cfe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] field_byte_o,
  input logic       byte_valid_o,
  input logic       field_done_o,
  input logic       field_found_o
);

  // a result is either a character or the done marker, never both or neither
  `CFE_ASSERT_NOW(a_kind_onehot, out_valid_o, byte_valid_o ^ field_done_o, "bad result kind")

  // character results never claim found, done results carry no byte
  `CFE_ASSERT_NOW(a_char_no_found, out_valid_o && byte_valid_o, !field_found_o,
                  "found set on character")
  `CFE_ASSERT_NOW(a_done_zero_byte, out_valid_o && field_done_o, field_byte_o == 8'd0,
                  "done carries a byte")

  // a stalled result stays put
  `CFE_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(field_byte_o) && $stable(field_done_o),
                   "stalled result changed")

  // an idle output means the input side can take a byte
  `CFE_ASSERT_NEXT(a_in_ready, !out_valid_o && !in_valid_i, in_ready_o,
                   "input stalled with empty output")

endmodule

bind csv_field_extractor cfe_checker u_cfe_checker (.*);
